@@ design/pcb_pkg.sv @@
// Shared types, constants and pixel arithmetic for the pixel compositing blender.
package pcb_pkg;

  // Configuration port geometry
  localparam int unsigned REG_IDX_W  = 3;
  localparam int unsigned REG_DATA_W = 32;

  // Pixel constants
  localparam logic [31:0] ALPHA_ONES = 32'hff000000;
  localparam logic [31:0] ALL_ONES   = 32'hffffffff;
  localparam logic [31:0] RGB_MASK   = 32'h00ffffff;
  localparam logic [31:0] LOW16_MASK = 32'h0000ffff;
  localparam logic [7:0]  BYTE_MASK  = 8'hff;
  localparam logic [15:0] ROUND_BIAS = 16'h0080;
  localparam logic [15:0] MASK_565_B = 16'h001f;
  localparam logic [15:0] MASK_565_G = 16'h07e0;
  localparam logic [15:0] MASK_565_R = 16'hf800;

  // Register indexes on the configuration port
  typedef enum logic [REG_IDX_W-1:0] {
    REG_BLEND_MODE   = 3'd0,
    REG_DEST_FORMAT  = 3'd1,
    REG_SOLID_COLOR  = 3'd2,
    REG_FORCE_OPAQUE = 3'd3,
    REG_DEPTH_MASK   = 3'd4
  } reg_idx_e;

  // Blend modes
  typedef enum logic [2:0] {
    MODE_OVER       = 3'd0,
    MODE_SOLID_A8   = 3'd1,
    MODE_SOLID_COMP = 3'd2,
    MODE_ADD        = 3'd3,
    MODE_COPY       = 3'd4
  } blend_mode_e;

  // Destination formats
  typedef enum logic [1:0] {
    FMT_ARGB8888 = 2'd0,
    FMT_RGB0888  = 2'd1,
    FMT_RGB565   = 2'd2
  } dest_fmt_e;

  // Configuration register set
  typedef struct packed {
    logic [2:0]  blend_mode;
    logic [1:0]  dest_format;
    logic [31:0] solid_color;
    logic        force_opaque;
    logic [31:0] depth_mask;
  } cfg_t;

  // Per-pixel control carried down the pipe
  typedef struct packed {
    logic        is_blend;   // result comes from the blend datapath
    logic        we;         // destination gets written
    logic [31:0] bypass;     // result when not blending
  } ctl_t;

  // Stage 1 payload: operands for the first multiply
  typedef struct packed {
    ctl_t        ctl;
    logic [31:0] src;
    logic [31:0] mask;
    logic [31:0] dest;
  } prep_t;

  // Stage 2 payload: source terms and per-channel coverage alpha
  typedef struct packed {
    ctl_t        ctl;
    logic [31:0] src_term;
    logic [31:0] cov_alpha;
    logic [31:0] dest;
  } mul_t;

  // Stage 3 payload: source terms and attenuated destination
  typedef struct packed {
    ctl_t        ctl;
    logic [31:0] src_term;
    logic [31:0] dst_term;
  } mix_t;

  // Normalized 8-bit multiply: t = a*b + 0x80, ((t >> 8) + t) >> 8
  function automatic logic [7:0] nmul(input logic [7:0] a, input logic [7:0] b);
    logic [15:0] t;
    logic [15:0] u;
    t = ({8'd0, a} * {8'd0, b}) + ROUND_BIAS;
    u = t + {8'd0, t[15:8]};
    return u[15:8];
  endfunction

  // Clamp a channel sum to 255
  function automatic logic [7:0] sat8(input logic [8:0] t);
    return t[8] ? BYTE_MASK : t[7:0];
  endfunction

  // Expand 565 to 8888 by bit replication, alpha zero
  function automatic logic [31:0] widen565(input logic [15:0] p);
    return {8'h00, p[15:11], p[15:13], p[10:5], p[10:9], p[4:0], p[4:2]};
  endfunction

  // Drop the low bits of each channel to pack 565
  function automatic logic [31:0] narrow565(input logic [31:0] v);
    logic [15:0] n;
    n = (v[18:3] & MASK_565_B) | (v[20:5] & MASK_565_G) | (v[23:8] & MASK_565_R);
    return {16'h0000, n};
  endfunction

  // Bring a stored destination pixel to 8888
  function automatic logic [31:0] load_dest(input logic [31:0] d, input logic [1:0] fmt);
    logic [31:0] r;
    case (fmt)
      FMT_RGB0888: r = d & RGB_MASK;
      FMT_RGB565:  r = widen565(d[15:0]);
      default:     r = d;
    endcase
    return r;
  endfunction

  // Bring an 8888 result back to the destination format
  function automatic logic [31:0] store_dest(input logic [31:0] v, input logic [1:0] fmt,
                                             input logic [31:0] dmask);
    logic [31:0] r;
    case (fmt)
      FMT_RGB0888: r = v & RGB_MASK;
      FMT_RGB565:  r = narrow565(v);
      default:     r = v & dmask;
    endcase
    return r;
  endfunction

endpackage

@@ design/pcb_in_if.sv @@
// Pixel request channel into the blender: source, mask and destination.
interface pcb_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] source_pixel;
  logic [31:0] mask_value;
  logic [31:0] dest_pixel;

  modport source (output valid, source_pixel, mask_value, dest_pixel, input ready);
  modport sink   (input valid, source_pixel, mask_value, dest_pixel, output ready);
endinterface

@@ design/pcb_out_if.sv @@
// Pixel result channel out of the blender: new pixel and write flag.
interface pcb_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] new_pixel;
  logic        write_enable;

  modport source (output valid, new_pixel, write_enable, input ready);
  modport sink   (input valid, new_pixel, write_enable, output ready);
endinterface

@@ design/pcb_cfg.sv @@
// Configuration register file of the blender.
module pcb_cfg
  import pcb_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [REG_IDX_W-1:0]  cfg_idx_i,
  input  logic [REG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q;

  // Write the addressed register, ignore unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.blend_mode   <= MODE_OVER;
      cfg_q.dest_format  <= FMT_ARGB8888;
      cfg_q.solid_color  <= '0;
      cfg_q.force_opaque <= 1'b0;
      cfg_q.depth_mask   <= ALL_ONES;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_BLEND_MODE:   cfg_q.blend_mode   <= cfg_data_i[2:0];
        REG_DEST_FORMAT:  cfg_q.dest_format  <= cfg_data_i[1:0];
        REG_SOLID_COLOR:  cfg_q.solid_color  <= cfg_data_i[31:0];
        REG_FORCE_OPAQUE: cfg_q.force_opaque <= cfg_data_i[0];
        REG_DEPTH_MASK:   cfg_q.depth_mask   <= cfg_data_i[31:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ design/pcb_prep.sv @@
// Stage 1: decode the mode, pick source and coverage, widen the destination.
module pcb_prep
  import pcb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] source_pixel_i,
  input  logic [31:0] mask_value_i,
  input  logic [31:0] dest_pixel_i,
  output logic        s1_valid_o,
  input  logic        s1_ready_i,
  output prep_t       s1_o
);

  logic        valid_q;
  prep_t       s1_q;
  prep_t       s1_d;
  logic        adv;
  logic [31:0] src_pick;
  logic        blend;

  assign adv        = !valid_q || s1_ready_i;
  assign in_ready_o = adv;

  // Decode the request into blend operands or a ready-made result
  always_comb begin
    src_pick = (cfg_i.blend_mode == MODE_OVER) ? source_pixel_i : cfg_i.solid_color;
    s1_d.src  = cfg_i.force_opaque ? (src_pick | ALPHA_ONES) : src_pick;
    s1_d.dest = load_dest(dest_pixel_i, cfg_i.dest_format);
    s1_d.mask = ALL_ONES;
    s1_d.ctl.bypass = dest_pixel_i;
    s1_d.ctl.we     = 1'b0;
    blend = 1'b0;
    case (cfg_i.blend_mode)
      MODE_OVER: begin
        blend = (s1_d.src[31:24] != 8'h00);
      end
      MODE_SOLID_A8: begin
        s1_d.mask = {4{mask_value_i[7:0]}};
        blend = (s1_d.src[31:24] != 8'h00) && (mask_value_i[7:0] != 8'h00);
      end
      MODE_SOLID_COMP: begin
        s1_d.mask = mask_value_i;
        blend = (s1_d.src[31:24] != 8'h00) && (mask_value_i != 32'h0);
      end
      MODE_ADD: begin
        s1_d.ctl.bypass = {24'h0, sat8({1'b0, source_pixel_i[7:0]} +
                                        {1'b0, dest_pixel_i[7:0]})};
        s1_d.ctl.we = 1'b1;
      end
      MODE_COPY: begin
        case (cfg_i.dest_format)
          FMT_RGB0888: s1_d.ctl.bypass = source_pixel_i & RGB_MASK;
          FMT_RGB565:  s1_d.ctl.bypass = source_pixel_i & LOW16_MASK;
          default:     s1_d.ctl.bypass = source_pixel_i & cfg_i.depth_mask;
        endcase
        s1_d.ctl.we = 1'b1;
      end
      default: begin
      end
    endcase
    s1_d.ctl.is_blend = blend;
    if (blend) begin
      s1_d.ctl.we = 1'b1;
    end
  end

  // Advance the valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv) begin
      valid_q <= in_valid_i;
    end
  end

  // Load the payload on an accepted request
  always_ff @(posedge clk_i) begin
    if (adv && in_valid_i) begin
      s1_q <= s1_d;
    end
  end

  assign s1_valid_o = valid_q;
  assign s1_o       = s1_q;

  // Add mode always writes
  a_add_writes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && cfg_i.blend_mode == MODE_ADD |=> s1_q.ctl.we)
    else $error("add request lost its write flag");

  // A blended pixel is always written
  a_blend_writes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && s1_q.ctl.is_blend |-> s1_q.ctl.we)
    else $error("blend request without write");

endmodule

@@ design/pcb_mix.sv @@
// Stages 2 and 3: source-in-coverage multiplies, then destination attenuation.
module pcb_mix
  import pcb_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  s1_valid_i,
  output logic  s1_ready_o,
  input  prep_t s1_i,
  output logic  s3_valid_o,
  input  logic  s3_ready_i,
  output mix_t  s3_o
);

  logic  v2_q;
  logic  v3_q;
  mul_t  s2_q;
  mul_t  s2_d;
  mix_t  s3_q;
  mix_t  s3_d;
  logic  adv2;
  logic  adv3;

  assign adv3       = !v3_q || s3_ready_i;
  assign adv2       = !v2_q || adv3;
  assign s1_ready_o = adv2;

  // Scale source channels and source alpha by the per-channel coverage
  always_comb begin
    s2_d.ctl  = s1_i.ctl;
    s2_d.dest = s1_i.dest;
    for (int c = 0; c < 4; c++) begin
      s2_d.src_term[c*8 +: 8]  = nmul(s1_i.src[c*8 +: 8], s1_i.mask[c*8 +: 8]);
      s2_d.cov_alpha[c*8 +: 8] = nmul(s1_i.src[31:24], s1_i.mask[c*8 +: 8]);
    end
  end

  // Attenuate the destination by the inverse coverage alpha
  always_comb begin
    s3_d.ctl      = s2_q.ctl;
    s3_d.src_term = s2_q.src_term;
    for (int c = 0; c < 4; c++) begin
      s3_d.dst_term[c*8 +: 8] = nmul(s2_q.dest[c*8 +: 8], ~s2_q.cov_alpha[c*8 +: 8]);
    end
  end

  // Advance the valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv2) begin
        v2_q <= s1_valid_i;
      end
      if (adv3) begin
        v3_q <= v2_q;
      end
    end
  end

  // Hold or advance the payloads
  always_ff @(posedge clk_i) begin
    if (adv2 && s1_valid_i) begin
      s2_q <= s2_d;
    end
    if (adv3 && v2_q) begin
      s3_q <= s3_d;
    end
  end

  assign s3_valid_o = v3_q;
  assign s3_o       = s3_q;

endmodule

@@ design/pcb_pack.sv @@
// Stage 4: sum and saturate, pack to the destination format, output register.
module pcb_pack
  import pcb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        s3_valid_i,
  output logic        s3_ready_o,
  input  mix_t        s3_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] new_pixel_o,
  output logic        write_enable_o
);

  logic        valid_q;
  logic [31:0] pixel_q;
  logic [31:0] pixel_d;
  logic        we_q;
  logic [31:0] blended;
  logic        adv;

  assign adv        = !valid_q || out_ready_i;
  assign s3_ready_o = adv;

  // Add the two terms per channel and pick the final pixel
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      blended[c*8 +: 8] = sat8({1'b0, s3_i.src_term[c*8 +: 8]} +
                               {1'b0, s3_i.dst_term[c*8 +: 8]});
    end
    pixel_d = s3_i.ctl.is_blend ? store_dest(blended, cfg_i.dest_format, cfg_i.depth_mask)
                                : s3_i.ctl.bypass;
  end

  // Advance the valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv) begin
      valid_q <= s3_valid_i;
    end
  end

  // Load the result
  always_ff @(posedge clk_i) begin
    if (adv && s3_valid_i) begin
      pixel_q <= pixel_d;
      we_q    <= s3_i.ctl.we;
    end
  end

  assign out_valid_o    = valid_q;
  assign new_pixel_o    = pixel_q;
  assign write_enable_o = we_q;

endmodule

@@ design/pixel_compositing_blender.sv @@
// Top level of the pixel compositing blender.
// Blends one premultiplied ARGB 8888 source pixel (or the solid colour under an 8-bit or
// per-channel mask) over one destination pixel and returns the new destination pixel with
// a write flag. The datapath is four register stages: decode and destination widening,
// source-in-coverage multiplies, destination attenuation multiplies, then sum, saturate,
// pack and the output register. A request is taken every cycle unless back-pressure has
// filled every stage. Back-pressure on the result channel holds each full stage in place
// and nothing is dropped or repeated. The user must write configuration only while no
// request is in flight; the block itself does not enforce this.
module pixel_compositing_blender
  import pcb_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [REG_IDX_W-1:0]  cfg_idx_i,
  input  logic [REG_DATA_W-1:0] cfg_data_i,
  pcb_in_if.sink                pix_in,
  pcb_out_if.source             pix_out
);

  cfg_t  cfg;
  logic  s1_valid;
  logic  s1_ready;
  prep_t s1;
  logic  s3_valid;
  logic  s3_ready;
  mix_t  s3;

  pcb_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  pcb_prep u_prep (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .in_valid_i     (pix_in.valid),
    .in_ready_o     (pix_in.ready),
    .source_pixel_i (pix_in.source_pixel),
    .mask_value_i   (pix_in.mask_value),
    .dest_pixel_i   (pix_in.dest_pixel),
    .s1_valid_o     (s1_valid),
    .s1_ready_i     (s1_ready),
    .s1_o           (s1)
  );

  pcb_mix u_mix (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s1_valid_i (s1_valid),
    .s1_ready_o (s1_ready),
    .s1_i       (s1),
    .s3_valid_o (s3_valid),
    .s3_ready_i (s3_ready),
    .s3_o       (s3)
  );

  pcb_pack u_pack (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .s3_valid_i     (s3_valid),
    .s3_ready_o     (s3_ready),
    .s3_i           (s3),
    .out_valid_o    (pix_out.valid),
    .out_ready_i    (pix_out.ready),
    .new_pixel_o    (pix_out.new_pixel),
    .write_enable_o (pix_out.write_enable)
  );

  // Input stalls only when the full pipe is blocked by the result channel
  a_stall_from_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pix_in.ready |-> pix_out.valid && !pix_out.ready)
    else $error("input stalled without output back-pressure");

  // A request accepted into an empty, unblocked pipe shows up at the output
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_in.valid && pix_in.ready && !s1_valid && !s3_valid && !pix_out.valid
      ##1 pix_out.ready ##1 pix_out.ready ##1 pix_out.ready |=> pix_out.valid)
    else $error("result missing after pipeline latency");

endmodule

@@ test/blend_result_checker.sv @@
// Result checker for the pixel compositing blender: predicts each request and compares results.
`timescale 1ns / 100ps

module blend_result_checker
  import pcb_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [REG_IDX_W-1:0]  cfg_idx_i,
  input  logic [REG_DATA_W-1:0] cfg_data_i,
  pcb_in_if                     pix_req,
  pcb_out_if                    pix_rsp,
  output int                    fail_count,
  output int                    pending_count
);

  typedef struct packed {
    logic [31:0] pixel;
    logic        wr;
  } blend_result_t;

  // Shadow copy of the configuration registers
  logic [2:0]  mode_q;
  logic [1:0]  fmt_q;
  logic [31:0] solid_q;
  logic        opaque_q;
  logic [31:0] depth_q;

  blend_result_t expected_pixels[$];
  int            mismatches;

  // (a*b + 0x80) folded back onto 8 bits
  function automatic logic [7:0] norm_mul8(input logic [7:0] a, input logic [7:0] b);
    logic [16:0] t;
    logic [16:0] u;
    t = a * b + 17'h80;
    u = (t >> 8) + t;
    return u[15:8];
  endfunction

  function automatic logic [7:0] clamp_sum(input logic [8:0] s);
    return (s > 9'd255) ? 8'hff : s[7:0];
  endfunction

  // Source OVER destination, per channel, alpha included
  function automatic logic [31:0] over_dest(input logic [31:0] s, input logic [31:0] d);
    logic [31:0] r;
    logic [7:0]  inv;
    inv = ~s[31:24];
    for (int c = 0; c < 4; c++)
      r[8*c +: 8] = clamp_sum({1'b0, norm_mul8(d[8*c +: 8], inv)} + {1'b0, s[8*c +: 8]});
    return r;
  endfunction

  // Scale all four channels by one coverage value
  function automatic logic [31:0] scale_px(input logic [31:0] s, input logic [7:0] m);
    logic [31:0] r;
    for (int c = 0; c < 4; c++)
      r[8*c +: 8] = norm_mul8(s[8*c +: 8], m);
    return r;
  endfunction

  // Component-alpha blend: each channel has its own coverage
  function automatic logic [31:0] comp_over(input logic [31:0] s, input logic [31:0] ma,
                                            input logic [31:0] d);
    logic [31:0] r;
    logic [7:0]  m;
    logic [7:0]  src_t;
    logic [7:0]  keep;
    for (int c = 0; c < 4; c++) begin
      m     = ma[8*c +: 8];
      src_t = norm_mul8(s[8*c +: 8], m);
      keep  = ~norm_mul8(s[31:24], m);
      r[8*c +: 8] = clamp_sum({1'b0, src_t} + {1'b0, norm_mul8(d[8*c +: 8], keep)});
    end
    return r;
  endfunction

  function automatic logic [31:0] expand_565(input logic [15:0] p);
    logic [4:0] r5;
    logic [5:0] g6;
    logic [4:0] b5;
    r5 = p[15:11];
    g6 = p[10:5];
    b5 = p[4:0];
    return {8'h00, r5, r5[4:2], g6, g6[5:4], b5, b5[4:2]};
  endfunction

  function automatic logic [31:0] load_fmt(input logic [31:0] d);
    case (fmt_q)
      FMT_RGB0888: return d & RGB_MASK;
      FMT_RGB565:  return expand_565(d[15:0]);
      default:     return d;
    endcase
  endfunction

  function automatic logic [31:0] store_fmt(input logic [31:0] v);
    case (fmt_q)
      FMT_RGB0888: return v & RGB_MASK;
      FMT_RGB565:  return {16'h0000, v[23:19], v[15:10], v[7:3]};
      default:     return v & depth_q;
    endcase
  endfunction

  // Expected new pixel and write flag for one request
  function automatic blend_result_t blend_pixel(input logic [31:0] sp, input logic [31:0] mv,
                                                input logic [31:0] dp);
    blend_result_t r;
    logic [31:0]   s;
    logic [31:0]   d;
    logic          full_cov;
    logic          zero_cov;
    r.pixel = dp;
    r.wr    = 1'b0;
    case (mode_q)
      MODE_OVER: begin
        s = opaque_q ? (sp | ALPHA_ONES) : sp;
        if (s[31:24] != 8'h00) begin
          d = (s[31:24] == 8'hff) ? s : over_dest(s, load_fmt(dp));
          r.pixel = store_fmt(d);
          r.wr    = 1'b1;
        end
      end
      MODE_SOLID_A8, MODE_SOLID_COMP: begin
        s = opaque_q ? (solid_q | ALPHA_ONES) : solid_q;
        if (mode_q == MODE_SOLID_A8) begin
          full_cov = (mv[7:0] == 8'hff);
          zero_cov = (mv[7:0] == 8'h00);
        end else begin
          full_cov = (mv == ALL_ONES);
          zero_cov = (mv == 32'h0);
        end
        if (s[31:24] != 8'h00 && !zero_cov) begin
          if (full_cov)
            d = (s[31:24] == 8'hff) ? s : over_dest(s, load_fmt(dp));
          else if (mode_q == MODE_SOLID_A8)
            d = over_dest(scale_px(s, mv[7:0]), load_fmt(dp));
          else
            d = comp_over(s, mv, load_fmt(dp));
          r.pixel = store_fmt(d);
          r.wr    = 1'b1;
        end
      end
      MODE_ADD: begin
        r.pixel = {24'h0, clamp_sum({1'b0, sp[7:0]} + {1'b0, dp[7:0]})};
        r.wr    = 1'b1;
      end
      MODE_COPY: begin
        case (fmt_q)
          FMT_RGB0888: r.pixel = sp & RGB_MASK;
          FMT_RGB565:  r.pixel = sp & LOW16_MASK;
          default:     r.pixel = sp & depth_q;
        endcase
        r.wr = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Compare results, queue predictions, track register writes
  always @(posedge clk_i or negedge rst_ni) begin
    blend_result_t want;
    if (!rst_ni) begin
      mode_q   <= MODE_OVER;
      fmt_q    <= FMT_ARGB8888;
      solid_q  <= '0;
      opaque_q <= 1'b0;
      depth_q  <= ALL_ONES;
      expected_pixels.delete();
      mismatches = 0;
      fail_count    <= 0;
      pending_count <= 0;
    end else begin
      if (pix_rsp.valid && pix_rsp.ready) begin
        if (expected_pixels.size() == 0) begin
          $error("result without request: new_pixel %h write_enable %b",
                 pix_rsp.new_pixel, pix_rsp.write_enable);
          mismatches++;
        end else begin
          want = expected_pixels.pop_front();
          if (pix_rsp.new_pixel !== want.pixel) begin
            $error("new_pixel: expected %h, got %h", want.pixel, pix_rsp.new_pixel);
            mismatches++;
          end
          if (pix_rsp.write_enable !== want.wr) begin
            $error("write_enable: expected %b, got %b", want.wr, pix_rsp.write_enable);
            mismatches++;
          end
        end
      end
      if (pix_req.valid && pix_req.ready)
        expected_pixels.push_back(blend_pixel(pix_req.source_pixel, pix_req.mask_value,
                                              pix_req.dest_pixel));
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_BLEND_MODE:   mode_q   <= cfg_data_i[2:0];
          REG_DEST_FORMAT:  fmt_q    <= cfg_data_i[1:0];
          REG_SOLID_COLOR:  solid_q  <= cfg_data_i;
          REG_FORCE_OPAQUE: opaque_q <= cfg_data_i[0];
          REG_DEPTH_MASK:   depth_q  <= cfg_data_i;
          default: ;
        endcase
      end
      fail_count    <= mismatches;
      pending_count <= expected_pixels.size();
    end
  end

endmodule

@@ test/tb_pixel_compositing_blender.sv @@
// Testbench top for the pixel compositing blender: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_pixel_compositing_blender;
  import pcb_pkg::*;

  localparam int          RANDOM_ITEMS   = 1950;
  localparam int          IDLE_LIMIT     = 2000;
  localparam logic [1:0]  FMT_UNUSED     = 2'd3;
  localparam logic [2:0]  MODE_RESERVED  = 3'd7;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [REG_IDX_W-1:0]  cfg_idx_i;
  logic [REG_DATA_W-1:0] cfg_data_i;

  int fail_count;
  int pending_count;
  int idle_cycles = 0;
  bit tx_steady   = 1'b0;
  bit rx_steady   = 1'b0;

  pcb_in_if  pix_req_if ();
  pcb_out_if pix_rsp_if ();

  pixel_compositing_blender u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pix_in     (pix_req_if),
    .pix_out    (pix_rsp_if)
  );

  blend_result_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .pix_req       (pix_req_if),
    .pix_rsp       (pix_rsp_if),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // End the run when neither channel moves for too long
  always @(posedge clk_i) begin
    if ((pix_req_if.valid && pix_req_if.ready) || (pix_rsp_if.valid && pix_rsp_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("pixel_compositing_blender: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: stall a random number of cycles before taking each result
  initial begin
    int stall;
    pix_rsp_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if ($urandom_range(0, 63) == 0) rx_steady = !rx_steady;
      stall = rx_steady ? 0 : $urandom_range(0, 13);
      repeat (stall) begin
        @(negedge clk_i);
        pix_rsp_if.ready <= 1'b0;
      end
      @(negedge clk_i);
      pix_rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(pix_rsp_if.valid && pix_rsp_if.ready));
    end
  end

  // Present one request after a random gap and hold it until taken
  task automatic send_pixel(input logic [31:0] src, input logic [31:0] msk,
                            input logic [31:0] dst);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 13);
    repeat (gap) begin
      @(negedge clk_i);
      pix_req_if.valid <= 1'b0;
    end
    @(negedge clk_i);
    pix_req_if.valid        <= 1'b1;
    pix_req_if.source_pixel <= src;
    pix_req_if.mask_value   <= msk;
    pix_req_if.dest_pixel   <= dst;
    do @(posedge clk_i); while (!(pix_req_if.valid && pix_req_if.ready));
  endtask

  // Stop sending and wait until every request has its result
  task automatic drain_pipe();
    @(negedge clk_i);
    pix_req_if.valid <= 1'b0;
    wait (pending_count == 0);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic set_config(input logic [2:0] mode, input logic [1:0] fmt,
                            input logic [31:0] solid, input logic opaque,
                            input logic [31:0] depth);
    drain_pipe();
    write_reg(REG_BLEND_MODE, {29'd0, mode});
    write_reg(REG_DEST_FORMAT, {30'd0, fmt});
    write_reg(REG_SOLID_COLOR, solid);
    write_reg(REG_FORCE_OPAQUE, {31'd0, opaque});
    write_reg(REG_DEPTH_MASK, depth);
  endtask

  // Mostly random words, with all-zero and all-one words mixed in
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 32'h0;
      1:       return ALL_ONES;
      default: return $urandom;
    endcase
  endfunction

  // Favor transparent and opaque alpha
  function automatic logic [31:0] pick_alpha(input logic [31:0] w);
    logic [31:0] r;
    r = w;
    case ($urandom_range(0, 5))
      0:       r[31:24] = 8'h00;
      1:       r[31:24] = 8'hff;
      default: ;
    endcase
    return r;
  endfunction

  // Favor empty and full coverage, for both mask kinds
  function automatic logic [31:0] pick_mask();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 7))
      0:       r = 32'h0;
      1:       r = ALL_ONES;
      2:       r[7:0] = 8'h00;
      3:       r[7:0] = 8'hff;
      default: ;
    endcase
    return r;
  endfunction

  task automatic randomize_config();
    logic [2:0]  mode;
    logic [31:0] depth;
    if ($urandom_range(0, 15) == 0) mode = 3'($urandom_range(MODE_COPY + 1, MODE_RESERVED));
    else mode = 3'($urandom_range(MODE_OVER, MODE_COPY));
    case ($urandom_range(0, 3))
      0:       depth = 32'h0;
      1:       depth = ALL_ONES;
      default: depth = $urandom;
    endcase
    set_config(mode, 2'($urandom_range(FMT_ARGB8888, FMT_UNUSED)), pick_alpha(pick_word()),
               ($urandom_range(0, 3) == 0), depth);
  endtask

  initial begin
    int total;
    int phase_len;
    rst_ni                  = 1'b0;
    cfg_we_i                = 1'b0;
    cfg_idx_i               = REG_BLEND_MODE;
    cfg_data_i              = '0;
    pix_req_if.valid        = 1'b0;
    pix_req_if.source_pixel = '0;
    pix_req_if.mask_value   = '0;
    pix_req_if.dest_pixel   = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: source over onto full-depth 8888
    send_pixel(32'h00123456, 32'h0, 32'hdeadbeef);
    send_pixel(32'hff102030, 32'h0, 32'h11223344);
    send_pixel(32'h80402010, 32'h0, ALL_ONES);
    send_pixel(ALL_ONES, ALL_ONES, 32'h0);

    // Forced opaque source onto 565, then a real blend onto 565
    set_config(MODE_OVER, FMT_RGB565, 32'h0, 1'b1, ALL_ONES);
    send_pixel(32'h0, 32'h0, ALL_ONES);
    set_config(MODE_OVER, FMT_RGB565, 32'h0, 1'b0, ALL_ONES);
    send_pixel(32'h80808080, 32'h0, 32'habcdf81f);

    // Unused format value behaves as 8888 with the depth mask
    set_config(MODE_OVER, FMT_UNUSED, 32'h0, 1'b0, 32'h00ff00ff);
    send_pixel(32'h40302010, 32'h0, ALL_ONES);

    // Solid colour under an 8-bit mask: empty, full, partial, low byte empty
    set_config(MODE_SOLID_A8, FMT_RGB0888, 32'h80402010, 1'b0, ALL_ONES);
    send_pixel(ALL_ONES, 32'h0, ALL_ONES);
    send_pixel(32'h0, 32'h000000ff, 32'hff123456);
    send_pixel(32'h0, 32'hffffff80, 32'h00abcdef);
    send_pixel(32'h0, 32'h00ffff00, 32'h12345678);

    // Transparent solid colour never writes
    set_config(MODE_SOLID_A8, FMT_ARGB8888, 32'h00ffffff, 1'b0, ALL_ONES);
    send_pixel(32'h0, 32'h000000ff, 32'h55555555);

    // Component mask onto 565
    set_config(MODE_SOLID_COMP, FMT_RGB565, 32'hffc08040, 1'b0, ALL_ONES);
    send_pixel(32'h0, 32'h0, 32'h0000ffff);
    send_pixel(32'h0, ALL_ONES, 32'h00001234);
    send_pixel(32'h0, 32'h00ff80ff, 32'h0000f81f);
    send_pixel(32'h0, 32'h01000000, ALL_ONES);

    // Saturating add ignores the format and the mask
    set_config(MODE_ADD, FMT_RGB565, ALL_ONES, 1'b1, 32'h0);
    send_pixel(ALL_ONES, ALL_ONES, ALL_ONES);
    send_pixel(32'h12345601, 32'h0, 32'habcdef02);

    // Copy through the depth mask and through 565
    set_config(MODE_COPY, FMT_ARGB8888, 32'h0, 1'b0, 32'hf0f0f0f0);
    send_pixel(ALL_ONES, 32'h0, 32'h0);
    set_config(MODE_COPY, FMT_RGB565, 32'h0, 1'b0, ALL_ONES);
    send_pixel(32'hdeadbeef, ALL_ONES, ALL_ONES);

    // Reserved mode leaves the destination alone
    set_config(MODE_RESERVED, FMT_ARGB8888, ALL_ONES, 1'b1, ALL_ONES);
    send_pixel(ALL_ONES, ALL_ONES, 32'h13579bdf);

    // Random phases, each under its own settings
    total = 0;
    while (total < RANDOM_ITEMS) begin
      randomize_config();
      tx_steady = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(40, 90);
      repeat (phase_len) begin
        send_pixel(pick_alpha(pick_word()), pick_mask(), pick_word());
        total++;
      end
    end

    drain_pipe();
    repeat (8) @(negedge clk_i);
    if (fail_count == 0 && pending_count == 0) begin
      $display("pixel_compositing_blender: match");
    end else begin
      $display("pixel_compositing_blender: mismatch");
    end
    $finish;
  end

endmodule
